// File: rtl/core/nafmt_pkg.sv
`default_nettype none

package nafmt_pkg;

  localparam logic [2:0] CMD_HEX8    = 3'd0;
  localparam logic [2:0] CMD_HEX8_SP = 3'd1;
  localparam logic [2:0] CMD_HEX32   = 3'd2;
  localparam logic [2:0] CMD_DUMP    = 3'd3;
  localparam logic [2:0] CMD_DEC99   = 3'd4;
  localparam logic [2:0] CMD_DEC16   = 3'd5;
  localparam logic [2:0] CMD_DATE    = 3'd6;
  localparam logic [2:0] CMD_NONE    = 3'd7;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ALPHA  = 8'h37;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] DEC99_MAX  = 8'd99;
  localparam logic [5:0] YEAR_MIN   = 6'd10;
  localparam logic [3:0] MONTH_MAX  = 4'd12;

  localparam logic [1:0] WIDX_TENS = 2'd3;
  localparam logic [3:0] HEX8_CHARS  = 4'd2;
  localparam logic [3:0] HEX32_CHARS = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEX,
    ST_SPACE,
    ST_ONE,
    ST_OPEN,
    ST_DIV,
    ST_DPUT,
    ST_UNITS,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic       put;
    logic [7:0] code;
    logic       last;
  } emit_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib > 4'd9) ? (wide + CH_ALPHA) : (wide + CH_ZERO);
  endfunction

  function automatic logic [15:0] dec_weight(input logic [1:0] idx);
    logic [15:0] w;
    case (idx)
      2'd0:    w = 16'd10000;
      2'd1:    w = 16'd1000;
      2'd2:    w = 16'd100;
      default: w = 16'd10;
    endcase
    return w;
  endfunction

  function automatic logic date_ok(input logic [31:0] v);
    return (v[4:0] != 5'd0) && (v[8:5] != 4'd0) && (v[8:5] <= MONTH_MAX) &&
           (v[14:9] > YEAR_MIN);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/number_to_ascii_formatter_core.sv
// channel  | dir | signals                                   | item
// s_axis   | in  | tvalid tready tdata[31:0] tuser[2:0]      | value, command
// m_axis   | out | tvalid tready tdata[7:0] tlast            | char_code, last
//
// One item gives 0 to 8 characters, at most one per cycle. Hex and dump
// commands emit their characters with no computing step between them;
// each decimal digit but the units is found by repeated subtraction in
// the shared 16-bit subtract/compare unit; the units digit is the rest.
// rst is synchronous; it drops any item in progress and empties the output.
// Output stalls hold the sequencer while it emits; a new item is taken once
// the last character of the previous one sits in the output register.
`default_nettype none

module number_to_ascii_formatter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value[31:0]
  input  wire logic [2:0]  s_axis_tuser,   // command[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // char_code[7:0]
  output logic             m_axis_tlast
);

  nafmt_pkg::emit_t emit;
  logic             idle;
  logic             out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = idle && !rst;

  nafmt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_val   (s_axis_tdata),
    .out_free (out_free),
    .idle     (idle),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.put) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (emit.put) begin
      m_axis_tdata <= emit.code;
      m_axis_tlast <= emit.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nafmt_seq.sv
`default_nettype none

module nafmt_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        in_cmd,
  input  wire logic [31:0]       in_val,
  input  wire logic              out_free,
  output logic                   idle,
  output nafmt_pkg::emit_t       emit
);

  nafmt_pkg::state_t state, state_next;
  logic [2:0]  cmd, cmd_next;
  logic [31:0] val, val_next;
  logic [15:0] work, work_next;
  logic [3:0]  cnt, cnt_next;
  logic [1:0]  widx, widx_next;
  logic [3:0]  digit, digit_next;
  logic        shown, shown_next;
  logic [1:0]  fld, fld_next;

  // shared subtract/compare unit
  logic [15:0] weight;
  logic [15:0] diff;
  logic        ge;

  assign weight = nafmt_pkg::dec_weight(widx);
  assign ge     = (work >= weight);
  assign diff   = work - weight;
  assign idle   = (state == nafmt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nafmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    cmd   <= cmd_next;
    val   <= val_next;
    work  <= work_next;
    cnt   <= cnt_next;
    widx  <= widx_next;
    digit <= digit_next;
    shown <= shown_next;
    fld   <= fld_next;
  end

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    val_next   = val;
    work_next  = work;
    cnt_next   = cnt;
    widx_next  = widx;
    digit_next = digit;
    shown_next = shown;
    fld_next   = fld;
    emit       = '0;

    case (state)
      nafmt_pkg::ST_IDLE: begin
        if (start) begin
          cmd_next = in_cmd;
          case (in_cmd)
            nafmt_pkg::CMD_HEX8, nafmt_pkg::CMD_HEX8_SP: begin
              val_next   = {in_val[7:0], 24'h0};
              cnt_next   = nafmt_pkg::HEX8_CHARS;
              state_next = nafmt_pkg::ST_HEX;
            end
            nafmt_pkg::CMD_HEX32: begin
              val_next   = in_val;
              cnt_next   = nafmt_pkg::HEX32_CHARS;
              state_next = nafmt_pkg::ST_HEX;
            end
            nafmt_pkg::CMD_DUMP: begin
              val_next   = in_val;
              state_next = nafmt_pkg::ST_ONE;
            end
            nafmt_pkg::CMD_DEC99: begin
              work_next  = (in_val[7:0] > nafmt_pkg::DEC99_MAX) ?
                           {8'h0, nafmt_pkg::DEC99_MAX} : {8'h0, in_val[7:0]};
              widx_next  = nafmt_pkg::WIDX_TENS;
              digit_next = 4'd0;
              state_next = nafmt_pkg::ST_DIV;
            end
            nafmt_pkg::CMD_DEC16: begin
              work_next  = in_val[15:0];
              widx_next  = 2'd0;
              digit_next = 4'd0;
              shown_next = 1'b0;
              state_next = nafmt_pkg::ST_DIV;
            end
            nafmt_pkg::CMD_DATE: begin
              if (nafmt_pkg::date_ok(in_val)) begin
                val_next   = in_val;
                fld_next   = 2'd0;
                state_next = nafmt_pkg::ST_OPEN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      nafmt_pkg::ST_HEX: begin
        if (out_free) begin
          emit.put  = 1'b1;
          emit.code = nafmt_pkg::hex_char(val[31:28]);
          emit.last = (cnt == 4'd1) && (cmd != nafmt_pkg::CMD_HEX8_SP);
          val_next  = {val[27:0], 4'h0};
          cnt_next  = cnt - 4'd1;
          if (cnt == 4'd1) begin
            state_next = (cmd == nafmt_pkg::CMD_HEX8_SP) ? nafmt_pkg::ST_SPACE :
                                                            nafmt_pkg::ST_IDLE;
          end
        end
      end

      nafmt_pkg::ST_SPACE: begin
        if (out_free) begin
          emit.put   = 1'b1;
          emit.code  = nafmt_pkg::CH_SPACE;
          emit.last  = 1'b1;
          state_next = nafmt_pkg::ST_IDLE;
        end
      end

      nafmt_pkg::ST_ONE: begin
        if (out_free) begin
          emit.put   = 1'b1;
          emit.code  = (val[7:0] < nafmt_pkg::CTRL_LIMIT) ? nafmt_pkg::CH_DOT : val[7:0];
          emit.last  = 1'b1;
          state_next = nafmt_pkg::ST_IDLE;
        end
      end

      nafmt_pkg::ST_OPEN: begin
        if (out_free) begin
          emit.put   = 1'b1;
          emit.code  = nafmt_pkg::CH_LPAREN;
          work_next  = {10'h0, val[14:9]};
          widx_next  = nafmt_pkg::WIDX_TENS;
          digit_next = 4'd0;
          state_next = nafmt_pkg::ST_DIV;
        end
      end

      nafmt_pkg::ST_DIV: begin
        if (ge) begin
          work_next  = diff;
          digit_next = digit + 4'd1;
        end else begin
          state_next = nafmt_pkg::ST_DPUT;
        end
      end

      nafmt_pkg::ST_DPUT: begin
        if (out_free) begin
          emit.put = 1'b1;
          if ((digit == 4'd0) && !shown && (cmd == nafmt_pkg::CMD_DEC16)) begin
            emit.code = nafmt_pkg::CH_SPACE;
          end else begin
            emit.code  = nafmt_pkg::CH_ZERO | {4'h0, digit};
            shown_next = 1'b1;
          end
          if (widx == nafmt_pkg::WIDX_TENS) begin
            state_next = nafmt_pkg::ST_UNITS;
          end else begin
            widx_next  = widx + 2'd1;
            digit_next = 4'd0;
            state_next = nafmt_pkg::ST_DIV;
          end
        end
      end

      nafmt_pkg::ST_UNITS: begin
        if (out_free) begin
          emit.put  = 1'b1;
          emit.code = nafmt_pkg::CH_ZERO | {4'h0, work[3:0]};
          if (cmd == nafmt_pkg::CMD_DATE) begin
            widx_next  = nafmt_pkg::WIDX_TENS;
            digit_next = 4'd0;
            fld_next   = fld + 2'd1;
            case (fld)
              2'd0: begin
                work_next  = {12'h0, val[8:5]};
                state_next = nafmt_pkg::ST_DIV;
              end
              2'd1: begin
                work_next  = {11'h0, val[4:0]};
                state_next = nafmt_pkg::ST_DIV;
              end
              default: begin
                state_next = nafmt_pkg::ST_CLOSE;
              end
            endcase
          end else begin
            emit.last  = 1'b1;
            state_next = nafmt_pkg::ST_IDLE;
          end
        end
      end

      nafmt_pkg::ST_CLOSE: begin
        if (out_free) begin
          emit.put   = 1'b1;
          emit.code  = nafmt_pkg::CH_RPAREN;
          emit.last  = 1'b1;
          state_next = nafmt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = nafmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/nafmt_chk.sv
`default_nettype none

module nafmt_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  a_none_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && (s_axis_tuser == nafmt_pkg::CMD_NONE) |=> s_axis_tready)
    else $error("unused command left block busy");

  a_bad_date: assert property (@(posedge clk) disable iff (rst)
    in_acc && (s_axis_tuser == nafmt_pkg::CMD_DATE) &&
      !nafmt_pkg::date_ok(s_axis_tdata) |=> s_axis_tready)
    else $error("invalid date left block busy");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (s_axis_tuser != nafmt_pkg::CMD_NONE) &&
      (s_axis_tuser != nafmt_pkg::CMD_DATE) |=> !s_axis_tready)
    else $error("block ready while item in progress");

endmodule

bind number_to_ascii_formatter_core nafmt_chk u_chk (.*);

`default_nettype wire

// File: bench/number_to_ascii_formatter_core_test.sv
`default_nettype none

module number_to_ascii_formatter_core_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 450;

  class char_scoreboard;
    typedef struct {
      bit [7:0] code;
      bit       last;
    } char_t;

    char_t expected_chars[$];
    char_t run[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_char(bit [7:0] c);
      char_t ch;
      ch.code = c;
      ch.last = 1'b0;
      run.push_back(ch);
    endfunction

    function bit [7:0] hex_ascii(bit [3:0] nib);
      return (nib > 4'd9) ? (8'h41 + nib - 8'd10) : (nafmt_pkg::CH_ZERO + nib);
    endfunction

    function void push_dec2(bit [7:0] b);
      bit [7:0] sat;
      sat = (b > nafmt_pkg::DEC99_MAX) ? nafmt_pkg::DEC99_MAX : b;
      push_char(nafmt_pkg::CH_ZERO + sat / 8'd10);
      push_char(nafmt_pkg::CH_ZERO + sat % 8'd10);
    endfunction

    function void push_dec16(bit [15:0] w);
      int rest;
      int d;
      int place;
      bit shown;
      int weights[4];
      weights = '{10000, 1000, 100, 10};
      rest = int'(w);
      shown = 1'b0;
      for (place = 0; place < 4; place++) begin
        d = rest / weights[place];
        rest = rest % weights[place];
        if (d == 0 && !shown) begin
          push_char(nafmt_pkg::CH_SPACE);
        end else begin
          shown = 1'b1;
          push_char(nafmt_pkg::CH_ZERO + d[7:0]);
        end
      end
      push_char(nafmt_pkg::CH_ZERO + rest[7:0]);
    endfunction

    // expected characters for one accepted item
    function void note_item(bit [2:0] cmd, bit [31:0] value);
      bit [4:0] day;
      bit [3:0] month;
      bit [5:0] year;
      int s;
      run.delete();
      case (cmd)
        nafmt_pkg::CMD_HEX8: begin
          push_char(hex_ascii(value[7:4]));
          push_char(hex_ascii(value[3:0]));
        end
        nafmt_pkg::CMD_HEX8_SP: begin
          push_char(hex_ascii(value[7:4]));
          push_char(hex_ascii(value[3:0]));
          push_char(nafmt_pkg::CH_SPACE);
        end
        nafmt_pkg::CMD_HEX32: begin
          for (s = 28; s >= 0; s -= 4) push_char(hex_ascii(value[s +: 4]));
        end
        nafmt_pkg::CMD_DUMP: begin
          push_char((value[7:0] < nafmt_pkg::CTRL_LIMIT) ? nafmt_pkg::CH_DOT : value[7:0]);
        end
        nafmt_pkg::CMD_DEC99: push_dec2(value[7:0]);
        nafmt_pkg::CMD_DEC16: push_dec16(value[15:0]);
        nafmt_pkg::CMD_DATE: begin
          day = value[4:0];
          month = value[8:5];
          year = value[14:9];
          if (day != 0 && month != 0 && month <= nafmt_pkg::MONTH_MAX &&
              year > nafmt_pkg::YEAR_MIN) begin
            push_char(nafmt_pkg::CH_LPAREN);
            push_dec2({2'b00, year});
            push_dec2({4'h0, month});
            push_dec2({3'b000, day});
            push_char(nafmt_pkg::CH_RPAREN);
          end
        end
        default: ;
      endcase
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_chars.push_back(run[i]);
    endfunction

    function void check_char(bit [7:0] code, bit last);
      char_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected char: char_code %h last %0d", code, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $error("char_code: expected %h, actual %h", want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  bit no_idle = 1'b0;
  int cycle_count = 0;
  char_scoreboard sb = new();

  number_to_ascii_formatter_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 5));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= value;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, value);
  endtask

  function automatic logic [31:0] random_value(input logic [2:0] cmd);
    logic [31:0] v;
    v = $urandom;
    case (cmd)
      nafmt_pkg::CMD_DATE: begin
        if ($urandom_range(0, 9) < 8) begin
          v[4:0] = 5'($urandom_range(1, 31));
          v[8:5] = 4'($urandom_range(1, 12));
          v[14:9] = 6'($urandom_range(11, 63));
        end else if ($urandom_range(0, 1) == 0) begin
          v[14:9] = 6'($urandom_range(0, 11));
        end
      end
      nafmt_pkg::CMD_DEC16: begin
        case ($urandom_range(0, 3))
          0: v[15:0] = 16'($urandom_range(0, 9));
          1: v[15:0] = 16'($urandom_range(0, 999));
          2: v[15:0] = 16'($urandom_range(0, 99999 % 65536));
          default: ;
        endcase
      end
      nafmt_pkg::CMD_DEC99: begin
        if ($urandom_range(0, 1) == 0) v[7:0] = 8'($urandom_range(0, 120));
      end
      default: ;
    endcase
    return v;
  endfunction

  // output side: random stall per char
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : int'($urandom_range(0, 5));
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    int n;
    logic [2:0] cmd;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(nafmt_pkg::CMD_HEX8, 32'h0000_0000);
    send_command(nafmt_pkg::CMD_HEX8, 32'hFFFF_FFFF);
    send_command(nafmt_pkg::CMD_HEX8_SP, 32'h1234_56A5);
    send_command(nafmt_pkg::CMD_HEX32, 32'h0000_0000);
    send_command(nafmt_pkg::CMD_HEX32, 32'hFFFF_FFFF);
    send_command(nafmt_pkg::CMD_HEX32, 32'h0123_ABCD);
    send_command(nafmt_pkg::CMD_DUMP, 32'hFFFF_FF00);
    send_command(nafmt_pkg::CMD_DUMP, 32'h0000_001F);
    send_command(nafmt_pkg::CMD_DUMP, 32'h0000_0020);
    send_command(nafmt_pkg::CMD_DUMP, 32'h0000_007F);
    send_command(nafmt_pkg::CMD_DUMP, 32'h0000_00FF);
    send_command(nafmt_pkg::CMD_DEC99, 32'hFFFF_FF00);
    send_command(nafmt_pkg::CMD_DEC99, 32'd99);
    send_command(nafmt_pkg::CMD_DEC99, 32'd100);
    send_command(nafmt_pkg::CMD_DEC99, 32'hFFFF_FFFF);
    send_command(nafmt_pkg::CMD_DEC16, 32'hFFFF_0000);
    send_command(nafmt_pkg::CMD_DEC16, 32'd10000);
    send_command(nafmt_pkg::CMD_DEC16, 32'd1009);
    send_command(nafmt_pkg::CMD_DEC16, 32'hFFFF_FFFF);
    send_command(nafmt_pkg::CMD_DATE, {16'hFFFF, 1'b1, 6'd63, 4'd12, 5'd31});
    send_command(nafmt_pkg::CMD_DATE, {16'h0, 1'b0, 6'd11, 4'd1, 5'd1});
    send_command(nafmt_pkg::CMD_DATE, {16'h0, 1'b0, 6'd20, 4'd5, 5'd0});
    send_command(nafmt_pkg::CMD_DATE, {16'h0, 1'b0, 6'd20, 4'd0, 5'd7});
    send_command(nafmt_pkg::CMD_DATE, {16'h0, 1'b0, 6'd20, 4'd13, 5'd7});
    send_command(nafmt_pkg::CMD_DATE, {16'h0, 1'b0, 6'd10, 4'd6, 5'd7});
    send_command(nafmt_pkg::CMD_NONE, 32'hFFFF_FFFF);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      no_idle = (n >= 100 && n < 160) || (n >= 350 && n < 400);
      if (n == 250) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      cmd = 3'($urandom_range(0, 7));
      send_command(cmd, random_value(cmd));
      n++;
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/nafmt_pkg.sv
rtl/core/nafmt_seq.sv
rtl/core/number_to_ascii_formatter_core.sv
rtl/core/nafmt_chk.sv
bench/number_to_ascii_formatter_core_test.sv
